// File: rtl/x86ma_pkg.sv
package x86ma_pkg;

  localparam logic [7:0] PFX_ADDR_SIZE = 8'h67;
  localparam logic [7:0] PFX_OPND_SIZE = 8'h66;
  localparam logic [3:0] REX_HIGH_NIB  = 4'h4;
  localparam int unsigned REX_W_BIT    = 3;
  localparam int unsigned REX_R_BIT    = 2;

  localparam logic [7:0] OP_MOV_RM8_R8  = 8'h88;
  localparam logic [7:0] OP_MOV_RM_R    = 8'h89;
  localparam logic [7:0] OP_MOV_R8_RM8  = 8'h8a;
  localparam logic [7:0] OP_MOV_R_RM    = 8'h8b;

  localparam logic [1:0] MOD_NO_DISP    = 2'b00;
  localparam logic [1:0] MOD_DISP8      = 2'b01;
  localparam logic [1:0] MOD_DISP32     = 2'b10;

  // opcode + modrm + displacement
  localparam logic [3:0] LEN_NO_DISP    = 4'd2;
  localparam logic [3:0] LEN_DISP8      = 4'd3;
  localparam logic [3:0] LEN_DISP32     = 4'd6;

  localparam logic [3:0] SLOT_SP        = 4'd4;

  localparam int unsigned CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MODE = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNSUPP  = 2'd1,
    STATUS_WIDE    = 2'd2,
    STATUS_NO_REG  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] reg_index;
    logic       is_write;
    logic [2:0] access_bytes;
    logic [3:0] instr_length;
    logic [3:0] reg_slot;
    logic       high_byte;
    logic       rex_seen;
  } out_t;

endpackage

// File: rtl/x86_mov_access_decoder.sv
// path: input register, then the single decode pass, then the result register
// throughput: one beat per cycle unless out_ready_i stalls; the decode pass sets it
// ready towards the input follows the result side combinationally, so no bubble under stall
// reset: rst_ni asynchronous active low, clears both stage valids and sets long_mode to 1
// payload registers are not reset
module x86_mov_access_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  x86ma_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output x86ma_pkg::out_t   out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import x86ma_pkg::*;

  logic       long_mode_q;
  logic       s1_valid_q;
  in_t        s1_data_q;
  logic       s2_valid_q;
  out_t       s2_data_q;
  logic       s2_free;
  logic       s1_move;
  logic [CFG_IDX_W-1:0] cfg_idx;

  // decode signals
  logic [7:0] b [5];
  logic [2:0] pos;
  logic [2:0] size;
  logic       have_rex;
  logic [7:0] rex;
  logic [7:0] op;
  logic [7:0] modrm;
  logic [1:0] mod_f;
  logic [3:0] extra;
  logic [3:0] reg_idx;
  status_e    status;
  out_t       res_d;

  assign cfg_idx = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == CFG_LONG_MODE) ? {31'd0, long_mode_q} : 32'd0;

  assign s2_free    = !s2_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;

  always_comb begin
    b[0] = s1_data_q.byte0;
    b[1] = s1_data_q.byte1;
    b[2] = s1_data_q.byte2;
    b[3] = s1_data_q.byte3;
    b[4] = s1_data_q.byte4;

    pos      = 3'd0;
    size     = 3'd4;
    have_rex = 1'b0;
    rex      = 8'd0;
    extra    = 4'd0;
    status   = STATUS_UNSUPP;
    reg_idx  = 4'd0;
    res_d    = '0;

    if (long_mode_q && b[0] == PFX_ADDR_SIZE) begin
      pos = 3'd1;
    end
    if (b[pos] == PFX_OPND_SIZE) begin
      pos  = pos + 3'd1;
      size = 3'd2;
    end
    if (long_mode_q && b[pos][7:4] == REX_HIGH_NIB) begin
      rex      = b[pos];
      have_rex = 1'b1;
      pos      = pos + 3'd1;
    end

    op    = b[pos];
    modrm = b[pos + 3'd1];
    mod_f = modrm[7:6];

    if (have_rex && rex[REX_W_BIT]) begin
      status = STATUS_WIDE;
    end else if (op == OP_MOV_RM8_R8 || op == OP_MOV_R8_RM8) begin
      if (mod_f == MOD_DISP32) begin
        status = STATUS_OK;
        size   = 3'd1;
        extra  = LEN_DISP32;
      end
    end else if (op == OP_MOV_RM_R || op == OP_MOV_R_RM) begin
      case (mod_f)
        MOD_DISP32: begin
          status = STATUS_OK;
          extra  = LEN_DISP32;
        end
        MOD_DISP8: begin
          status = STATUS_OK;
          extra  = LEN_DISP8;
        end
        MOD_NO_DISP: begin
          status = STATUS_OK;
          extra  = LEN_NO_DISP;
        end
        default: begin
          status = STATUS_UNSUPP;
        end
      endcase
    end

    reg_idx = {have_rex && rex[REX_R_BIT], modrm[5:3]};

    res_d.rex_seen = have_rex;
    if (status == STATUS_OK) begin
      res_d.reg_index    = reg_idx;
      res_d.is_write     = (op == OP_MOV_RM8_R8 || op == OP_MOV_RM_R);
      res_d.access_bytes = size;
      res_d.instr_length = {1'b0, pos} + extra;
      res_d.reg_slot     = reg_idx;
      // legacy byte registers ah..bh live in bits 15:8 of slots 0..3
      if (reg_idx[3:2] == 2'b01 && size == 3'd1 && !have_rex) begin
        res_d.reg_slot  = {2'b00, reg_idx[1:0]};
        res_d.high_byte = 1'b1;
        res_d.status    = STATUS_OK;
      end else if (reg_idx == SLOT_SP) begin
        res_d.status    = STATUS_NO_REG;
      end else begin
        res_d.status    = STATUS_OK;
      end
    end else begin
      res_d.status = status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b1;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && cfg_idx == CFG_LONG_MODE) begin
        long_mode_q <= pwdata[0];
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (s1_move) begin
      s2_data_q <= res_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  a_move_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o)
    else $error("decoded beat did not reach the result register");

  a_reject_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_UNSUPP || out_data_o.status == STATUS_WIDE)
    |-> out_data_o.instr_length == 4'd0 && out_data_o.access_bytes == 3'd0
        && out_data_o.reg_slot == 4'd0 && !out_data_o.is_write)
    else $error("rejected instruction carries decode fields");

  a_ok_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_OK
    |-> (out_data_o.access_bytes == 3'd1 || out_data_o.access_bytes == 3'd2
         || out_data_o.access_bytes == 3'd4) && out_data_o.reg_slot != SLOT_SP)
    else $error("accepted instruction with bad width or stack pointer slot");

  a_high_byte_legacy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.high_byte
    |-> out_data_o.status == STATUS_OK && out_data_o.access_bytes == 3'd1
        && !out_data_o.rex_seen)
    else $error("high byte lane outside a legacy byte access");

  a_wide_has_rex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_WIDE |-> out_data_o.rex_seen)
    else $error("wide operand rejection without a rex prefix");

endmodule

// File: test/tb_x86_mov_access_decoder.sv
module tb_x86_mov_access_decoder;
  import x86ma_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam logic [2:0]  ADDR_LONG_MODE = {CFG_LONG_MODE, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        win_valid = 1'b0;
  logic        win_ready;
  in_t         win_data = '0;
  logic        dec_valid;
  logic        dec_ready = 1'b0;
  out_t        dec_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  in_t  pending_windows[$];
  out_t expected_decodes[$];
  logic mode_q = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   sink_hold = 1'b0;

  int windows_sent = 0;
  int decodes_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int backpressure_cycles = 0;
  int status_tally[4] = '{0, 0, 0, 0};

  x86_mov_access_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .in_data_i   (win_data),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_data_o  (dec_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // decode of one five-byte window, as the block should see it
  function automatic out_t predict_access(in_t w, logic lm);
    logic [7:0] b [5];
    int         p;
    logic [7:0] rex;
    logic [7:0] opc;
    logic [7:0] modrm;
    logic       have_rex;
    logic       ok;
    logic [2:0] width;
    logic [3:0] len;
    logic [3:0] extra;
    out_t       r;
    b[0] = w.byte0;
    b[1] = w.byte1;
    b[2] = w.byte2;
    b[3] = w.byte3;
    b[4] = w.byte4;
    p = 0;
    len = '0;
    extra = '0;
    width = 3'd4;
    rex = '0;
    have_rex = 1'b0;
    ok = 1'b0;
    r = '0;
    r.status = STATUS_UNSUPP;
    if (lm && b[p] == PFX_ADDR_SIZE) begin
      p++;
      len++;
    end
    if (b[p] == PFX_OPND_SIZE) begin
      p++;
      len++;
      width = 3'd2;
    end
    if (lm && b[p][7:4] == REX_HIGH_NIB) begin
      rex = b[p];
      have_rex = 1'b1;
      p++;
      len++;
    end
    r.rex_seen = have_rex;
    if (have_rex && rex[REX_W_BIT]) begin
      r.status = STATUS_WIDE;
      return r;
    end
    opc = b[p];
    modrm = b[p+1];
    if (opc == OP_MOV_RM8_R8 || opc == OP_MOV_R8_RM8) begin
      if (modrm[7:6] == MOD_DISP32) begin
        ok = 1'b1;
        width = 3'd1;
        extra = LEN_DISP32;
      end
    end else if (opc == OP_MOV_RM_R || opc == OP_MOV_R_RM) begin
      case (modrm[7:6])
        MOD_DISP32: begin
          ok = 1'b1;
          extra = LEN_DISP32;
        end
        MOD_DISP8: begin
          ok = 1'b1;
          extra = LEN_DISP8;
        end
        MOD_NO_DISP: begin
          ok = 1'b1;
          extra = LEN_NO_DISP;
        end
        default: ;
      endcase
    end
    if (!ok) return r;
    r.status = STATUS_OK;
    r.is_write = (opc == OP_MOV_RM8_R8 || opc == OP_MOV_RM_R);
    r.reg_index = {have_rex & rex[REX_R_BIT], modrm[5:3]};
    r.access_bytes = width;
    r.instr_length = len + extra;
    r.reg_slot = r.reg_index;
    // legacy byte registers 4..7 are bits 15:8 of slots 0..3
    if (r.reg_index[3:2] == 2'b01 && width == 3'd1 && !have_rex) begin
      r.reg_slot = r.reg_index - 4'd4;
      r.high_byte = 1'b1;
    end else if (r.reg_index == SLOT_SP) begin
      r.status = STATUS_NO_REG;
    end
    return r;
  endfunction

  function automatic in_t pack_window(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                      logic [7:0] b3, logic [7:0] b4);
    in_t w;
    w.byte0 = b0;
    w.byte1 = b1;
    w.byte2 = b2;
    w.byte3 = b3;
    w.byte4 = b4;
    return w;
  endfunction

  // mostly prefix chains ending in a mov, with random content; the rest is noise
  function automatic in_t random_window(logic lm);
    logic [7:0] b [5];
    logic [3:0] rex_low;
    int         n;
    n = 0;
    for (int i = 0; i < 5; i++) b[i] = 8'($urandom_range(255));
    if ($urandom_range(99) < 75) begin
      if ($urandom_range(99) < (lm ? 30 : 5)) begin
        b[n] = PFX_ADDR_SIZE;
        n++;
      end
      if ($urandom_range(99) < 35) begin
        b[n] = PFX_OPND_SIZE;
        n++;
      end
      if ($urandom_range(99) < (lm ? 45 : 5)) begin
        rex_low = 4'($urandom_range(15));
        if ($urandom_range(3) != 0) rex_low[REX_W_BIT] = 1'b0;
        b[n] = {REX_HIGH_NIB, rex_low};
        n++;
      end
      case ($urandom_range(9))
        0, 1: b[n] = OP_MOV_RM8_R8;
        2, 3: b[n] = OP_MOV_R8_RM8;
        4, 5: b[n] = OP_MOV_RM_R;
        6, 7: b[n] = OP_MOV_R_RM;
        default: ;
      endcase
      if ((b[n] == OP_MOV_RM8_R8 || b[n] == OP_MOV_R8_RM8) && $urandom_range(99) < 80)
        b[n+1][7:6] = MOD_DISP32;
    end
    return pack_window(b[0], b[1], b[2], b[3], b[4]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on decode %0d: %s got %0d want %0d", decodes_seen, what, got, want);
    mismatches++;
  endtask

  // driver: next window from the queue, held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid <= 1'b0;
    end else begin
      if (win_valid && win_ready) begin
        expected_decodes.push_back(predict_access(win_data, mode_q));
        windows_sent++;
      end
      if (!win_valid || win_ready) begin
        if (pending_windows.size() > 0 && $urandom_range(99) >= idle_pct) begin
          win_data <= pending_windows.pop_front();
          win_valid <= 1'b1;
        end else begin
          win_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_ready <= 1'b0;
    end else begin
      dec_ready <= !sink_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: each result beat against the oldest prediction
  always @(posedge clk_i) begin : monitor_blk
    out_t want;
    if (rst_ni && dec_valid && dec_ready) begin
      if (expected_decodes.size() == 0) begin
        report_mismatch("result with nothing outstanding, status", int'(dec_data.status), -1);
      end else begin
        want = expected_decodes.pop_front();
        if (dec_data.status !== want.status)
          report_mismatch("status", int'(dec_data.status), int'(want.status));
        if (dec_data.reg_index !== want.reg_index)
          report_mismatch("reg_index", int'(dec_data.reg_index), int'(want.reg_index));
        if (dec_data.is_write !== want.is_write)
          report_mismatch("is_write", int'(dec_data.is_write), int'(want.is_write));
        if (dec_data.access_bytes !== want.access_bytes)
          report_mismatch("access_bytes", int'(dec_data.access_bytes),
                          int'(want.access_bytes));
        if (dec_data.instr_length !== want.instr_length)
          report_mismatch("instr_length", int'(dec_data.instr_length),
                          int'(want.instr_length));
        if (dec_data.reg_slot !== want.reg_slot)
          report_mismatch("reg_slot", int'(dec_data.reg_slot), int'(want.reg_slot));
        if (dec_data.high_byte !== want.high_byte)
          report_mismatch("high_byte", int'(dec_data.high_byte), int'(want.high_byte));
        if (dec_data.rex_seen !== want.rex_seen)
          report_mismatch("rex_seen", int'(dec_data.rex_seen), int'(want.rex_seen));
        status_tally[want.status]++;
      end
      decodes_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (win_valid && win_ready) || (dec_valid && dec_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat in %0d cycles, %0d decodes outstanding",
                 WATCHDOG_LIMIT, expected_decodes.size());
        $display("Test completed with failures");
        $finish;
      end
    end
    if (rst_ni && win_valid && !win_ready) backpressure_cycles <= backpressure_cycles + 1;
  end

  task automatic write_long_mode(logic v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_LONG_MODE;
    pwdata <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_q = v;
  endtask

  // sender pauses until every window is taken and every decode is back, then lets the pipeline settle
  task automatic drain;
    while (pending_windows.size() > 0 || win_valid || expected_decodes.size() > 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(int count, logic lm, int idle, int stall);
    write_long_mode(lm);
    idle_pct = idle;
    stall_pct = stall;
    @(negedge clk_i);
    for (int i = 0; i < count; i++) pending_windows.push_back(random_window(lm));
    drain();
  endtask

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    idle_mix = '{0, 56, 0, 19};
    stall_mix = '{0, 0, 56, 19};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // long mode corner cases
    write_long_mode(1'b1);
    @(negedge clk_i);
    pending_windows.push_back(pack_window(8'h88, 8'h80, 8'h11, 8'h22, 8'h33));
    pending_windows.push_back(pack_window(8'h8a, 8'ha0, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h88, 8'hbc, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h89, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h8b, 8'h48, 8'h7f, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h8b, 8'hb8, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h89, 8'hc0, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h88, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h89, 8'h20, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h66, 8'h89, 8'h08, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h67, 8'h66, 8'h44, 8'h8b, 8'h60));
    pending_windows.push_back(pack_window(8'h48, 8'h89, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h4c, 8'h89, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h40, 8'h88, 8'ha0, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h41, 8'h8a, 8'hb8, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h44, 8'h8a, 8'h80, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h67, 8'h8b, 8'h45, 8'h10, 8'h00));
    pending_windows.push_back(pack_window(8'h66, 8'h66, 8'h89, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    drain();

    // 32-bit mode: 0x67 and REX bytes are plain opcodes there
    write_long_mode(1'b0);
    @(negedge clk_i);
    pending_windows.push_back(pack_window(8'h67, 8'h89, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h40, 8'h89, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h66, 8'h8b, 8'h80, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h88, 8'ha0, 8'h00, 8'h00, 8'h00));
    pending_windows.push_back(pack_window(8'h89, 8'h20, 8'h00, 8'h00, 8'h00));
    drain();

    for (int k = 0; k < 8; k++) run_random(85, !k[0], idle_mix[k>>1], stall_mix[k>>1]);

    // hold the result side off long enough for the input to back up
    write_long_mode(1'b1);
    idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    sink_hold = 1'b1;
    for (int i = 0; i < 48; i++) pending_windows.push_back(random_window(1'b1));
    repeat (HOLD_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    sink_hold = 1'b0;
    drain();

    if (expected_decodes.size() > 0)
      report_mismatch("decodes never returned", expected_decodes.size(), 0);
    $display("%0d windows in both address modes, %0d decodes checked, input stalled %0d cycles",
             windows_sent, decodes_seen, backpressure_cycles);
    $display("status mix: ok %0d, unsupported %0d, wide operand %0d, stack pointer %0d",
             status_tally[STATUS_OK], status_tally[STATUS_UNSUPP],
             status_tally[STATUS_WIDE], status_tally[STATUS_NO_REG]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/x86ma_pkg.sv
rtl/x86_mov_access_decoder.sv
test/tb_x86_mov_access_decoder.sv
